FILE: hdl/perspective_warp_bilinear_defines.svh
// Assertion macros shared by the perspective warp RTL.
// No dependencies; included by modules that carry assertions.
`ifndef PERSPECTIVE_WARP_BILINEAR_DEFINES_SVH
`define PERSPECTIVE_WARP_BILINEAR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define PWB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define PWB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pwb_pkg.sv
// Shared constants, types and width helpers of the perspective warp block.
// No dependencies.
package pwb_pkg;

    localparam int IMAGE_WIDTH_DEF  = 256;
    localparam int IMAGE_HEIGHT_DEF = 256;
    localparam int COEF_W = 21;
    localparam int REG_W  = 63;
    localparam int PIX_W  = 8;
    localparam int POS_W  = 8;
    localparam int FRAC_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DENOMINATOR = 2'd0,
        CFG_HORIZONTAL  = 2'd1,
        CFG_VERTICAL    = 2'd2
    } t_cfg_idx;

    // Four bilinear neighbors: a=(m,n) b=(m,n+1) c=(m+1,n) d=(m+1,n+1)
    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] d;
    } t_nbr;

    // Signed width of a centered coordinate
    function automatic int coord_w(int w, int h);
        int m;
        m = 256;
        if (w > m) m = w;
        if (h > m) m = h;
        return $clog2(m) + 1;
    endfunction

    // Width of w, x numerator and y numerator
    function automatic int sum_w(int w, int h);
        return COEF_W + coord_w(w, h) + 2;
    endfunction

    // Quotient magnitude bits that still can land inside the frame
    function automatic int quot_w(int w, int h);
        int m;
        m = (w > h) ? w : h;
        return $clog2((m >> 1) * 256 + 2);
    endfunction

    // Signed coefficient from a packed row register
    function automatic logic signed [COEF_W-1:0] coef(logic [REG_W-1:0] r, int slot);
        return $signed(r[slot*COEF_W +: COEF_W]);
    endfunction

endpackage

FILE: hdl/pwb_in_if.sv
// Input channel: source writes and output-pixel requests.
// Depends on pwb_pkg.
interface pwb_in_if;
    import pwb_pkg::*;
    logic             valid;
    logic             ready;
    logic             func;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, func, row, col, pixel, input ready);
    modport sink   (input valid, func, row, col, pixel, output ready);
endinterface

FILE: hdl/pwb_out_if.sv
// Output channel: interpolated output pixels.
// Depends on pwb_pkg.
interface pwb_out_if;
    import pwb_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] out_pixel;
    modport source (output valid, out_row, out_col, out_pixel, input ready);
    modport sink   (input valid, out_row, out_col, out_pixel, output ready);
endinterface

FILE: hdl/pwb_homography.sv
// Homography front end: centered coordinates times nine coefficients, summed.
// Depends on pwb_pkg. Products are registered, then their sums.
module pwb_homography #(
    parameter int W = pwb_pkg::IMAGE_WIDTH_DEF,
    parameter int H = pwb_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic [pwb_pkg::POS_W-1:0]                  i_row,
    input  logic [pwb_pkg::POS_W-1:0]                  i_col,
    input  logic [pwb_pkg::REG_W-1:0]                  i_den_row,
    input  logic [pwb_pkg::REG_W-1:0]                  i_hor_row,
    input  logic [pwb_pkg::REG_W-1:0]                  i_ver_row,
    output logic signed [pwb_pkg::sum_w(W, H)-1:0]     o_w,
    output logic signed [pwb_pkg::sum_w(W, H)-1:0]     o_nx,
    output logic signed [pwb_pkg::sum_w(W, H)-1:0]     o_ny
);
    import pwb_pkg::*;

    localparam int CW = coord_w(W, H);
    localparam int PW = COEF_W + CW;
    localparam int SW = sum_w(W, H);

    logic signed [CW-1:0] w_j;
    logic signed [CW-1:0] w_i;
    logic [REG_W-1:0]     w_rows [3];
    logic signed [PW-1:0] r_pd [3][3];
    logic signed [SW-1:0] r_sum [3];

    // Center the requested position on the frame
    assign w_j = $signed({{(CW-POS_W){1'b0}}, i_col}) - $signed(CW'(W / 2));
    assign w_i = $signed({{(CW-POS_W){1'b0}}, i_row}) - $signed(CW'(H / 2));

    assign w_rows[0] = i_den_row;
    assign w_rows[1] = i_hor_row;
    assign w_rows[2] = i_ver_row;

    // Multiply column and row terms, carry the constant term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int t = 0; t < 3; t++) begin
                r_pd[t][0] <= PW'(coef(w_rows[t], 0)) * PW'(w_j);
                r_pd[t][1] <= PW'(coef(w_rows[t], 1)) * PW'(w_i);
                r_pd[t][2] <= PW'(coef(w_rows[t], 2));
            end
        end
    end

    // Add the three terms of each row
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int t = 0; t < 3; t++) begin
                r_sum[t] <= SW'(r_pd[t][0]) + SW'(r_pd[t][1]) + SW'(r_pd[t][2]);
            end
        end
    end

    assign o_w  = r_sum[0];
    assign o_nx = r_sum[1];
    assign o_ny = r_sum[2];

endmodule

FILE: hdl/pwb_divider.sv
// Pipelined floor divider: floor(num*256/den), one quotient bit per stage,
// then split into frame index, fraction and an out-of-frame flag. Depends on pwb_pkg.
module pwb_divider #(
    parameter int SW  = 32,
    parameter int QN  = 16,
    parameter int DIM = pwb_pkg::IMAGE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [SW-1:0]        i_num,
    input  logic signed [SW-1:0]        i_den,
    output logic [$clog2(DIM)-1:0]      o_idx,
    output logic [pwb_pkg::FRAC_W-1:0]  o_frac,
    output logic                        o_bad
);
    import pwb_pkg::*;

    localparam int AW   = SW + FRAC_W;
    localparam int XW   = AW + QN + 1;
    localparam int XQ   = QN + 2;
    localparam int IW   = $clog2(DIM);
    localparam int HALF = DIM / 2;
    localparam logic signed [XQ-1:0] LIM = XQ'(HALF * 256);

    logic [AW-1:0] r_rem  [QN+1];
    logic [SW-1:0] r_b    [QN+1];
    logic [QN-1:0] r_q    [QN+1];
    logic          r_neg  [QN+1];
    logic          r_zero [QN+1];
    logic          r_ovf  [QN+1];

    logic signed [SW:0] w_na;
    logic signed [SW:0] w_nb;

    // Take magnitudes and note the quotient sign
    assign w_na = i_num[SW-1] ? -(SW+1)'(i_num) : (SW+1)'(i_num);
    assign w_nb = i_den[SW-1] ? -(SW+1)'(i_den) : (SW+1)'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {w_na[SW-1:0], {FRAC_W{1'b0}}};
            r_b[0]    <= w_nb[SW-1:0];
            r_q[0]    <= '0;
            r_neg[0]  <= i_num[SW-1] ^ i_den[SW-1];
            r_zero[0] <= (i_den == '0);
            r_ovf[0]  <= 1'b0;
        end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar s = 1; s <= QN; s++) begin : g_step
        localparam int K = QN - s;
        logic [XW-1:0] w_trial;
        logic          w_ge;
        logic          w_ovf;

        assign w_trial = XW'(r_b[s-1]) << K;
        assign w_ge    = XW'(r_rem[s-1]) >= w_trial;

        if (s == 1) begin : g_first
            // Quotient too large for the frame at any sign
            assign w_ovf = XW'(r_rem[s-1]) >= (XW'(r_b[s-1]) << QN);
        end else begin : g_rest
            assign w_ovf = r_ovf[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? AW'(XW'(r_rem[s-1]) - w_trial) : r_rem[s-1];
                r_b[s]    <= r_b[s-1];
                r_q[s]    <= {r_q[s-1][QN-2:0], w_ge};
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_ovf[s]  <= w_ovf;
            end
        end
    end

    logic signed [XQ-1:0] w_uq;
    logic signed [XQ-1:0] w_xq;
    logic                 w_nz;
    logic                 w_out;

    // Apply the sign with a true floor and check the frame bounds
    assign w_nz  = (r_rem[QN] != '0);
    assign w_uq  = $signed({2'b00, r_q[QN]});
    assign w_xq  = r_neg[QN] ? (-w_uq - $signed(XQ'(w_nz))) : w_uq;
    assign w_out = (w_xq < -LIM) || (w_xq >= LIM);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_idx  <= IW'(w_xq >>> FRAC_W) + IW'(HALF);
            o_frac <= w_xq[FRAC_W-1:0];
            o_bad  <= r_zero[QN] || r_ovf[QN] || w_out;
        end
    end

endmodule

FILE: hdl/pwb_frame_store.sv
// Source frame in four banks split by row and column parity, so the four
// neighbors come out together. Depends on pwb_pkg. Read addresses, then bank data, are registered.
module pwb_frame_store #(
    parameter int W = pwb_pkg::IMAGE_WIDTH_DEF,
    parameter int H = pwb_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_wr,
    input  logic [pwb_pkg::POS_W-1:0]   i_wr_row,
    input  logic [pwb_pkg::POS_W-1:0]   i_wr_col,
    input  logic [pwb_pkg::PIX_W-1:0]   i_wr_pixel,
    input  logic [$clog2(H)-1:0]        i_rd_row,
    input  logic [$clog2(W)-1:0]        i_rd_col,
    output pwb_pkg::t_nbr               o_nbr
);
    import pwb_pkg::*;

    localparam int RW = $clog2(H);
    localparam int CI = $clog2(W);
    localparam int WB = (W + 1) / 2;
    localparam int HB = (H + 1) / 2;
    localparam int BD = WB * HB;
    localparam int AB = $clog2(BD);

    logic [AB-1:0]    r_raddr [4];
    logic             r_rok   [4];
    logic [AB-1:0]    r_waddr;
    logic [1:0]       r_wbank;
    logic             r_we;
    logic [PIX_W-1:0] r_wdata;
    logic [1:0]       r_par;

    logic [PIX_W-1:0] r_rdata [4];
    logic             r_ok2   [4];
    logic [1:0]       r_par2;

    logic             w_win;
    assign w_win = (32'(i_wr_row) < H) && (32'(i_wr_col) < W);

    // Bank addresses: each bank picks m or m+1, n or n+1 by parity
    for (genvar b = 0; b < 4; b++) begin : g_addr
        localparam logic RPAR = 1'((b >> 1) & 1);
        localparam logic CPAR = 1'(b & 1);
        logic [RW:0] w_r;
        logic [CI:0] w_c;
        assign w_r = (i_rd_row[0] == RPAR) ? (RW+1)'(i_rd_row) : (RW+1)'(i_rd_row) + 1'b1;
        assign w_c = (i_rd_col[0] == CPAR) ? (CI+1)'(i_rd_col) : (CI+1)'(i_rd_col) + 1'b1;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_raddr[b] <= AB'(32'(w_r >> 1) * WB + 32'(w_c >> 1));
                r_rok[b]   <= (32'(w_r) < H) && (32'(w_c) < W);
            end
        end
    end

    // Write address and bank select
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_waddr <= AB'(32'(i_wr_row >> 1) * WB + 32'(i_wr_col >> 1));
            r_wbank <= {i_wr_row[0], i_wr_col[0]};
            r_we    <= i_wr && w_win;
            r_wdata <= i_wr_pixel;
            r_par   <= {i_rd_row[0], i_rd_col[0]};
        end
    end

    // Bank memories: one write and one registered read per cycle while i_en is high
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIX_W-1:0] r_mem [BD];

        always_ff @(posedge i_clk) begin
            if (i_en && r_we && (r_wbank == 2'(b))) begin
                r_mem[r_waddr] <= r_wdata;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rdata[b] <= r_mem[r_raddr[b]];
                r_ok2[b]   <= r_rok[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_par2 <= r_par;
        end
    end

    // Route banks to neighbors; drop neighbors beyond the edge
    always_comb begin
        logic [1:0] ka, kb, kc, kd;
        ka = r_par2;
        kb = r_par2 ^ 2'b01;
        kc = r_par2 ^ 2'b10;
        kd = r_par2 ^ 2'b11;
        o_nbr.a = r_ok2[ka] ? r_rdata[ka] : '0;
        o_nbr.b = r_ok2[kb] ? r_rdata[kb] : '0;
        o_nbr.c = r_ok2[kc] ? r_rdata[kc] : '0;
        o_nbr.d = r_ok2[kd] ? r_rdata[kd] : '0;
    end

endmodule

FILE: hdl/pwb_blend.sv
// Bilinear blend of four neighbors, truncated and clamped to 8 bits.
// Depends on pwb_pkg. Row blend and result are registered in turn; a bad position gives 0.
module pwb_blend (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  pwb_pkg::t_nbr               i_nbr,
    input  logic [pwb_pkg::FRAC_W-1:0]  i_p,
    input  logic [pwb_pkg::FRAC_W-1:0]  i_q,
    input  logic                        i_bad,
    output logic [pwb_pkg::PIX_W-1:0]   o_pixel
);
    import pwb_pkg::*;

    logic [16:0]       r_top;
    logic [16:0]       r_bot;
    logic [FRAC_W-1:0] r_q;
    logic              r_bad;
    logic [8:0]        w_ip;
    logic [8:0]        w_iq;
    logic [25:0]       w_tot;

    // Blend along the row
    assign w_ip = 9'd256 - 9'(i_p);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top <= 17'(w_ip) * 17'(i_nbr.a) + 17'(i_p) * 17'(i_nbr.b);
            r_bot <= 17'(w_ip) * 17'(i_nbr.c) + 17'(i_p) * 17'(i_nbr.d);
            r_q   <= i_q;
            r_bad <= i_bad;
        end
    end

    // Blend along the column, truncate, clamp
    assign w_iq  = 9'd256 - 9'(r_q);
    assign w_tot = (26'(w_iq) * 26'(r_top) + 26'(r_q) * 26'(r_bot)) >> 16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_bad) begin
                o_pixel <= '0;
            end else if (w_tot > 26'd255) begin
                o_pixel <= 8'd255;
            end else begin
                o_pixel <= w_tot[PIX_W-1:0];
            end
        end
    end

endmodule

FILE: hdl/perspective_warp_bilinear.sv
// Perspective warp with bilinear interpolation. Items with func=0 write a
// source pixel into a four-bank frame store; items with func=1 request an
// output pixel and give one result. One item is taken per clock while the
// skid register is empty. A request passes the homography, the two dividers,
// which resolve one quotient bit per stage (QN is the quotient width set by
// the larger frame side), the frame store and the blend. Writes ride the
// same pipeline, so a request always sees every write accepted before it. A
// skid register holds one more result while a result waits. Configure only while idle.
module perspective_warp_bilinear #(
    parameter int IMAGE_WIDTH  = pwb_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = pwb_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pwb_in_if.sink                          i_in,
    pwb_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [pwb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pwb_pkg::REG_W-1:0]       i_cfg_data
);
    import pwb_pkg::*;
    `include "perspective_warp_bilinear_defines.svh"

    localparam int SW = sum_w(IMAGE_WIDTH, IMAGE_HEIGHT);
    localparam int QN = quot_w(IMAGE_WIDTH, IMAGE_HEIGHT);
    localparam int DL = QN + 2;
    localparam int NS = DL + 6;
    localparam int FS = DL + 1;
    localparam int LS = DL + 5;

    typedef struct packed {
        logic             valid;
        logic             func;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pixel;
    } t_side;

    typedef struct packed {
        logic [FRAC_W-1:0] p;
        logic [FRAC_W-1:0] q;
        logic              bad;
    } t_mid;

    logic [REG_W-1:0] r_den_row;
    logic [REG_W-1:0] r_hor_row;
    logic [REG_W-1:0] r_ver_row;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den_row <= '0;
            r_hor_row <= '0;
            r_ver_row <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DENOMINATOR: r_den_row <= i_cfg_data;
                CFG_HORIZONTAL:  r_hor_row <= i_cfg_data;
                CFG_VERTICAL:    r_ver_row <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    logic w_en;
    logic r_skid_v;
    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    // Sideband line that travels alongside the arithmetic
    t_side r_side [NS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_side[0] <= '{valid: i_in.valid, func: i_in.func, row: i_in.row,
                           col: i_in.col, pixel: i_in.pixel};
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic signed [SW-1:0] w_w;
    logic signed [SW-1:0] w_nx;
    logic signed [SW-1:0] w_ny;

    pwb_homography #(.W(IMAGE_WIDTH), .H(IMAGE_HEIGHT)) u_homography (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_row     (i_in.row),
        .i_col     (i_in.col),
        .i_den_row (r_den_row),
        .i_hor_row (r_hor_row),
        .i_ver_row (r_ver_row),
        .o_w       (w_w),
        .o_nx      (w_nx),
        .o_ny      (w_ny)
    );

    logic [$clog2(IMAGE_WIDTH)-1:0]  w_cidx;
    logic [$clog2(IMAGE_HEIGHT)-1:0] w_ridx;
    logic [FRAC_W-1:0]               w_p;
    logic [FRAC_W-1:0]               w_q;
    logic                            w_bad_x;
    logic                            w_bad_y;

    pwb_divider #(.SW(SW), .QN(QN), .DIM(IMAGE_WIDTH)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_nx),
        .i_den  (w_w),
        .o_idx  (w_cidx),
        .o_frac (w_p),
        .o_bad  (w_bad_x)
    );

    pwb_divider #(.SW(SW), .QN(QN), .DIM(IMAGE_HEIGHT)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_ny),
        .i_den  (w_w),
        .o_idx  (w_ridx),
        .o_frac (w_q),
        .o_bad  (w_bad_y)
    );

    // Hold fractions and the drop flag across the frame store
    t_mid r_mid [2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mid[0] <= '{p: w_p, q: w_q, bad: w_bad_x || w_bad_y};
            r_mid[1] <= r_mid[0];
        end
    end

    t_nbr w_nbr;

    pwb_frame_store #(.W(IMAGE_WIDTH), .H(IMAGE_HEIGHT)) u_frame (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_wr       (r_side[FS].valid && (r_side[FS].func == FUNC_WRITE)),
        .i_wr_row   (r_side[FS].row),
        .i_wr_col   (r_side[FS].col),
        .i_wr_pixel (r_side[FS].pixel),
        .i_rd_row   (w_ridx),
        .i_rd_col   (w_cidx),
        .o_nbr      (w_nbr)
    );

    logic [PIX_W-1:0] w_pix;

    pwb_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_nbr   (w_nbr),
        .i_p     (r_mid[1].p),
        .i_q     (r_mid[1].q),
        .i_bad   (r_mid[1].bad),
        .o_pixel (w_pix)
    );

    // Output register with one skid entry behind it
    logic             w_pv;
    logic             w_oload;
    logic             r_out_v;
    logic [POS_W-1:0] r_out_row;
    logic [POS_W-1:0] r_out_col;
    logic [PIX_W-1:0] r_out_pix;
    logic [POS_W-1:0] r_skid_row;
    logic [POS_W-1:0] r_skid_col;
    logic [PIX_W-1:0] r_skid_pix;

    assign w_pv    = r_side[LS].valid && (r_side[LS].func == FUNC_REQUEST);
    assign w_oload = !r_out_v || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_oload) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_pv;
            end
        end else if (w_en && w_pv) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            if (r_skid_v) begin
                r_out_row <= r_skid_row;
                r_out_col <= r_skid_col;
                r_out_pix <= r_skid_pix;
            end else begin
                r_out_row <= r_side[LS].row;
                r_out_col <= r_side[LS].col;
                r_out_pix <= w_pix;
            end
        end else if (w_en) begin
            r_skid_row <= r_side[LS].row;
            r_skid_col <= r_side[LS].col;
            r_skid_pix <= w_pix;
        end
    end

    assign o_out.valid     = r_out_v;
    assign o_out.out_row   = r_out_row;
    assign o_out.out_col   = r_out_col;
    assign o_out.out_pixel = r_out_pix;

    // The skid entry is only ever filled behind a waiting result
    `PWB_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid full with output empty")
    // A finished request is never dropped
    `PWB_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, w_en && w_pv, r_out_v, "finished request lost")
    // A stalled output diverts the next result into the skid entry
    `PWB_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, w_en && w_pv && r_out_v && !o_out.ready, r_skid_v, "skid not filled on stall")

endmodule
